>>> sv/avtf_pkg.sv
// Shared types, constants and helper functions for the averaged voltage text formatter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package avtf_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int CHAR_W          = 8;
  localparam int SAMPLES_DEFAULT = 8;
  localparam int MEAN_W          = 10;
  localparam int SCALE_NUM       = 500;
  localparam int SCALE_DEN       = 1023;
  localparam int PROD_W          = 19;
  localparam int HV_W            = 9;
  localparam int DIGIT_W         = 4;
  localparam int POS_W           = 4;
  localparam int QUEUE_DEPTH     = 2;

  // floor(2^20 / 1023) gives a quotient that is low by at most one.
  localparam int DEN_SHIFT = 20;
  localparam int DEN_RECIP = (1 << DEN_SHIFT) / SCALE_DEN;
  localparam int DEN_PROD_W = PROD_W + 11;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_V     = 8'h56;
  localparam logic [CHAR_W-1:0] CHAR_O     = 8'h6F;
  localparam logic [CHAR_W-1:0] CHAR_L     = 8'h6C;
  localparam logic [CHAR_W-1:0] CHAR_T     = 8'h74;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

  // Character positions within one output line.
  localparam logic [POS_W-1:0] POS_HUND  = 4'd0;
  localparam logic [POS_W-1:0] POS_DOT   = 4'd1;
  localparam logic [POS_W-1:0] POS_TENS  = 4'd2;
  localparam logic [POS_W-1:0] POS_ONES  = 4'd3;
  localparam logic [POS_W-1:0] POS_SPACE = 4'd4;
  localparam logic [POS_W-1:0] POS_V     = 4'd5;
  localparam logic [POS_W-1:0] POS_O     = 4'd6;
  localparam logic [POS_W-1:0] POS_L     = 4'd7;
  localparam logic [POS_W-1:0] POS_T     = 4'd8;
  localparam logic [POS_W-1:0] POS_CR    = 4'd9;
  localparam logic [POS_W-1:0] POS_LF    = 4'd10;

  typedef struct packed {
    logic [DIGIT_W-1:0] hund;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } digits_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Splits a value of 0..500 into decimal digits with independent compares.
  function automatic digits_t to_digits(input logic [HV_W-1:0] hv);
    digits_t            d;
    logic [HV_W-1:0]    base_h;
    logic [HV_W-1:0]    rem_h;
    logic [6:0]         base_t;
    logic [6:0]         rem_t;
    d.hund = '0;
    d.tens = '0;
    base_h = '0;
    base_t = '0;
    for (int k = 1; k <= 5; k++) begin
      if (hv >= HV_W'(100 * k)) begin
        d.hund = DIGIT_W'(k);
        base_h = HV_W'(100 * k);
      end
    end
    rem_h = hv - base_h;
    rem_t = rem_h[6:0];
    for (int k = 1; k <= 9; k++) begin
      if (rem_t >= 7'(10 * k)) begin
        d.tens = DIGIT_W'(k);
        base_t = 7'(10 * k);
      end
    end
    rem_t  = rem_t - base_t;
    d.ones = rem_t[DIGIT_W-1:0];
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] char_at(input digits_t d,
                                                input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    unique case (pos)
      POS_HUND:  c = CHAR_ZERO + CHAR_W'(d.hund);
      POS_DOT:   c = CHAR_DOT;
      POS_TENS:  c = CHAR_ZERO + CHAR_W'(d.tens);
      POS_ONES:  c = CHAR_ZERO + CHAR_W'(d.ones);
      POS_SPACE: c = CHAR_SPACE;
      POS_V:     c = CHAR_V;
      POS_O:     c = CHAR_O;
      POS_L:     c = CHAR_L;
      POS_T:     c = CHAR_T;
      POS_CR:    c = CHAR_CR;
      POS_LF:    c = CHAR_LF;
      default:   c = CHAR_LF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/avtf_channels.sv
// Valid/ready channel interfaces: converter samples in, text characters out.
// Depends on avtf_pkg for the field widths.
`default_nettype none

interface avtf_sample_if import avtf_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface avtf_char_if import avtf_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              line_end;

  modport source (output valid, output text_char, output line_end, input ready);
  modport sink   (input valid, input text_char, input line_end, output ready);
endinterface

`default_nettype wire

>>> sv/avtf_front.sv
// Front end: accumulates samples and turns each finished group into three voltage digits.
// Depends on avtf_pkg and avtf_sample_if.
`default_nettype none

module avtf_front import avtf_pkg::*; #(
  parameter int SAMPLES_PER_READING = SAMPLES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  avtf_sample_if.sink         in_ch,
  input  q_stat_t             q_stat,
  output logic                push,
  output digits_t             push_data
);

  localparam int CNT_W   = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int SUM_W   = $clog2(SAMPLES_PER_READING * 1023 + 1);
  localparam int RECIP_W = SUM_W + 1;
  localparam int MPROD_W = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L = (64'd1 << SUM_W) / SAMPLES_PER_READING;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int STAGES  = 7;

  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [STAGES-1:0] vld_r;
  logic              adv;
  logic              group_done;
  logic [SUM_W-1:0]  sum_nxt;

  logic [SUM_W-1:0]      s1_sum_r;
  logic [SUM_W-1:0]      s2_sum_r;
  logic [MEAN_W-1:0]     s2_q_r;
  logic [MEAN_W-1:0]     s3_mean_r;
  logic [PROD_W-1:0]     s4_prod_r;
  logic [PROD_W-1:0]     s5_prod_r;
  logic [HV_W-1:0]       s5_q_r;
  logic [HV_W-1:0]       s6_hv_r;
  digits_t               s7_dig_r;

  logic [MPROD_W-1:0]    mean_prod;
  logic [SUM_W-1:0]      mean_rem;
  logic [DEN_PROD_W-1:0] hv_prod;
  logic [PROD_W-1:0]     hv_rem;

  // The whole pipeline moves together; it only holds when the digits at
  // its end cannot be written into a full queue.
  assign adv         = !vld_r[STAGES-1] || !q_stat.full;
  assign in_ch.ready = adv;
  assign push        = vld_r[STAGES-1] && !q_stat.full;
  assign push_data   = s7_dig_r;

  assign sum_nxt    = sum_r + SUM_W'(in_ch.sample);
  assign group_done = (cnt_r == CNT_W'(SAMPLES_PER_READING - 1));

  // Mean by reciprocal: the estimate is at most one low, fixed by one compare.
  assign mean_prod = MPROD_W'(s1_sum_r) * MPROD_W'(RECIP);
  assign mean_rem  = s2_sum_r - SUM_W'(s2_q_r) * SUM_W'(SAMPLES_PER_READING);
  assign hv_prod   = DEN_PROD_W'(s4_prod_r) * DEN_PROD_W'(DEN_RECIP);
  assign hv_rem    = s5_prod_r - PROD_W'(s5_q_r) * PROD_W'(SCALE_DEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_ch.valid && group_done};
      if (in_ch.valid) begin
        if (group_done) begin
          cnt_r <= '0;
          sum_r <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
          sum_r <= sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum_r  <= sum_nxt;
      s2_sum_r  <= s1_sum_r;
      s2_q_r    <= mean_prod[SUM_W +: MEAN_W];
      s3_mean_r <= (mean_rem >= SUM_W'(SAMPLES_PER_READING)) ? s2_q_r + MEAN_W'(1) : s2_q_r;
      s4_prod_r <= PROD_W'(s3_mean_r) * PROD_W'(SCALE_NUM);
      s5_prod_r <= s4_prod_r;
      s5_q_r    <= hv_prod[DEN_SHIFT +: HV_W];
      s6_hv_r   <= (hv_rem >= PROD_W'(SCALE_DEN)) ? s5_q_r + HV_W'(1) : s5_q_r;
      s7_dig_r  <= to_digits(s6_hv_r);
    end
  end

endmodule

`default_nettype wire

>>> sv/avtf_queue.sv
// Short queue of finished readings between the front end and the character sequencer.
// Depends on avtf_pkg.
`default_nettype none

module avtf_queue import avtf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  digits_t push_data,
  input  logic    pop,
  output digits_t head,
  output q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  digits_t           mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> sv/avtf_back.sv
// Back end: walks the eleven characters of each queued reading into the output register.
// Depends on avtf_pkg and avtf_char_if.
`default_nettype none

module avtf_back import avtf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  digits_t       head,
  input  q_stat_t       q_stat,
  output logic          pop,
  avtf_char_if.source   out_ch
);

  logic              out_vld_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W-1:0]  pos_nxt;
  logic              load;

  assign out_ch.valid     = out_vld_r;
  assign out_ch.text_char = char_r;
  assign out_ch.line_end  = last_r;

  // The output register refills whenever it is empty or being taken.
  assign load    = !out_vld_r || out_ch.ready;
  assign pop     = load && !q_stat.empty && (pos_r == POS_LF);
  assign pos_nxt = (pos_r == POS_LF) ? POS_HUND : pos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      pos_r     <= POS_HUND;
    end else if (load) begin
      out_vld_r <= !q_stat.empty;
      if (!q_stat.empty) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_stat.empty) begin
      char_r <= char_at(head, pos_r);
      last_r <= (pos_r == POS_LF);
    end
  end

endmodule

`default_nettype wire

>>> sv/averaged_voltage_text_formatter_top.sv
// Top level of the averaged voltage text formatter: front end, reading queue, back end.
// Depends on avtf_pkg, avtf_channels, avtf_front, avtf_queue and avtf_back.
`default_nettype none

// Each group of SAMPLES_PER_READING samples is averaged (truncated mean), scaled to
// hundredths of a volt as mean*500/1023 rounded down, and sent as the eleven characters
// "d.dd Volt", CR, LF, one per output transfer, with line_end set on the LF. A sample is
// taken in every cycle while the front pipeline can move; the last sample of a group
// passes through the front pipeline registers into the reading queue, and its first
// character is registered into the output when the character sequencer is idle. The
// character sequencer sends one character per cycle while the output is ready, so a
// reading holds the output for eleven transfers; the two-entry queue absorbs bursts.
// Input ready drops only when the queue is full and a finished reading waits at the
// end of the front pipeline.
module averaged_voltage_text_formatter_top import avtf_pkg::*; #(
  parameter int SAMPLES_PER_READING = SAMPLES_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  avtf_sample_if.sink   in_ch,
  avtf_char_if.source   out_ch
);

  logic    push;
  logic    pop;
  digits_t push_data;
  digits_t head;
  q_stat_t q_stat;

  avtf_front #(
    .SAMPLES_PER_READING(SAMPLES_PER_READING)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  avtf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  avtf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("reading queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("reading queue written while full");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.full)
    else $error("input stalled while the reading queue has room");

  a_end_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.line_end) |-> (out_ch.text_char == CHAR_LF))
    else $error("line end flagged on a character other than line feed");

endmodule

`default_nettype wire
